[design/lsr_pkg.sv]
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared types and constants of the L-system symbol rewriter.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  localparam logic [7:0] LETTER_FIRST = 8'h41;
  localparam logic [7:0] LETTER_LAST  = 8'h5A;

  typedef enum logic [1:0] {
    CMD_WRITE_CHAR = 2'd0,
    CMD_SET_RULE   = 2'd1,
    CMD_REWRITE    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SET     = 2'd1,
    OP_REWRITE = 2'd2,
    OP_PASS    = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] slot;
    logic [5:0] pos;
    logic [7:0] chr;
    logic [6:0] len;
    logic       reg_flag;
    logic [7:0] sym;
  } entry_t;

endpackage

[design/lsr_front.sv]
// ----------------------------------------------------------------------------
// lsr_front
// Accepts input words, decodes the command and letter slot, drops words
// without effect and hands the rest to the work queue.
// ----------------------------------------------------------------------------
module lsr_front import lsr_pkg::*; #(
  parameter int unsigned MAX_RULE_LEN = 64,
  parameter int unsigned NUM_LETTERS  = 26
) (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] symbol_i,
  input  logic [5:0] position_i,
  input  logic [7:0] rule_char_i,
  input  logic [6:0] rule_length_i,
  input  logic       registered_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output entry_t     q_data_o
);

  logic [7:0] idx;
  logic       slot_ok;
  logic       keep;

  assign idx     = symbol_i - LETTER_FIRST;
  assign slot_ok = (symbol_i >= LETTER_FIRST) && (symbol_i <= LETTER_LAST) &&
                   (idx < 8'(NUM_LETTERS));

  always_comb begin
    q_data_o.slot     = idx[4:0];
    q_data_o.pos      = position_i;
    q_data_o.chr      = rule_char_i;
    q_data_o.len      = (rule_length_i > 7'(MAX_RULE_LEN)) ? 7'(MAX_RULE_LEN)
                                                            : rule_length_i;
    q_data_o.reg_flag = registered_i;
    q_data_o.sym      = symbol_i;
    q_data_o.op       = OP_PASS;
    keep              = 1'b0;
    case (command_i)
      CMD_WRITE_CHAR: begin
        q_data_o.op = OP_WRITE;
        keep        = slot_ok && (7'(position_i) < 7'(MAX_RULE_LEN));
      end
      CMD_SET_RULE: begin
        q_data_o.op = OP_SET;
        keep        = slot_ok;
      end
      CMD_REWRITE: begin
        q_data_o.op = slot_ok ? OP_REWRITE : OP_PASS;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

[design/lsr_fifo.sv]
// ----------------------------------------------------------------------------
// lsr_fifo
// Short work queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module lsr_fifo import lsr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t data_o
);

  entry_t            slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    cnt_d    = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

[design/lsr_back.sv]
// ----------------------------------------------------------------------------
// lsr_back
// Executes queued work: updates rule tables and text memory, and streams
// rule characters through a read stage and an output register.
// ----------------------------------------------------------------------------
module lsr_back import lsr_pkg::*; #(
  parameter int unsigned MAX_RULE_LEN = 64,
  parameter int unsigned NUM_LETTERS  = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_data_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       last_o
);

  localparam int unsigned POS_W     = (MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1;
  localparam int unsigned LEN_W     = $clog2(MAX_RULE_LEN + 1);
  localparam int unsigned SLOT_W    = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
  localparam int unsigned MEM_DEPTH = NUM_LETTERS * (2 ** POS_W);
  localparam int unsigned ADDR_W    = SLOT_W + POS_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              rule_valid_q [NUM_LETTERS];
  logic [LEN_W-1:0]  rule_len_q   [NUM_LETTERS];
  logic [7:0]        rule_mem     [MEM_DEPTH];
  logic [7:0]        rd_data_q;

  logic              s1_valid_q, s1_mem_q, s1_last_q;
  logic [7:0]        s1_sym_q;
  logic              out_valid_q, out_last_q;
  logic [7:0]        out_symbol_q;

  logic              adv_out, issue_ok;
  logic              issue, iss_mem, iss_last;
  logic [7:0]        iss_sym;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              mem_we, tab_we;
  logic [SLOT_W-1:0] e_slot;
  logic [LEN_W-1:0]  e_len;

  assign adv_out  = !out_valid_q || out_ready_i;
  assign issue_ok = !s1_valid_q || adv_out;
  assign e_slot   = q_data_i.slot[SLOT_W-1:0];
  assign e_len    = q_data_i.len[LEN_W-1:0];
  assign wr_addr  = {e_slot, q_data_i.pos[POS_W-1:0]};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    slot_d   = slot_q;
    q_pop_o  = 1'b0;
    issue    = 1'b0;
    iss_mem  = 1'b0;
    iss_last = 1'b0;
    iss_sym  = q_data_i.sym;
    rd_addr  = {e_slot, POS_W'(0)};
    mem_we   = 1'b0;
    tab_we   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.op)
            OP_WRITE: begin
              q_pop_o = 1'b1;
              mem_we  = 1'b1;
            end
            OP_SET: begin
              q_pop_o = 1'b1;
              tab_we  = 1'b1;
            end
            OP_REWRITE: begin
              if (issue_ok) begin
                q_pop_o = 1'b1;
                if (rule_valid_q[e_slot]) begin
                  if (rule_len_q[e_slot] != '0) begin
                    issue    = 1'b1;
                    iss_mem  = 1'b1;
                    iss_last = (rule_len_q[e_slot] == LEN_W'(1));
                    if (!iss_last) begin
                      state_d = ST_EMIT;
                      cnt_d   = LEN_W'(1);
                      len_d   = rule_len_q[e_slot];
                      slot_d  = e_slot;
                    end
                  end
                end else begin
                  issue    = 1'b1;
                  iss_last = 1'b1;
                end
              end
            end
            default: begin
              if (issue_ok) begin
                q_pop_o  = 1'b1;
                issue    = 1'b1;
                iss_last = 1'b1;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        rd_addr = {slot_q, cnt_q[POS_W-1:0]};
        if (issue_ok) begin
          issue    = 1'b1;
          iss_mem  = 1'b1;
          iss_last = (cnt_q == len_q - LEN_W'(1));
          cnt_d    = cnt_q + LEN_W'(1);
          if (iss_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        rule_valid_q[i] <= 1'b0;
        rule_len_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      slot_q  <= slot_d;
      if (tab_we) begin
        rule_valid_q[e_slot] <= q_data_i.reg_flag;
        rule_len_q[e_slot]   <= e_len;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (adv_out) begin
        s1_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rule_mem[wr_addr] <= q_data_i.chr;
    end
    if (issue && iss_mem) begin
      rd_data_q <= rule_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_mem_q  <= iss_mem;
      s1_last_q <= iss_last;
      s1_sym_q  <= iss_sym;
    end
    if (adv_out && s1_valid_q) begin
      out_symbol_q <= s1_mem_q ? rd_data_q : s1_sym_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_symbol_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q != '0 && cnt_q < len_q)
    else $error("emit counter out of range");
  a_emit_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !q_pop_o) else $error("pop during emit");
  a_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s1_valid_q) else $error("issued word lost");
`endif

endmodule

[design/lsystem_symbol_rewriter_core.sv]
// ----------------------------------------------------------------------------
// lsystem_symbol_rewriter_core
// One rewriting pass of an L-system over a stream of symbols.
// ----------------------------------------------------------------------------
// Command words load rule characters and set rule length and flag for the
// letters A to Z; rewrite words emit the registered rule of a letter, one
// character per cycle while the output is not stalled, with last on the
// final one, or pass any other symbol through as a single word. A front
// stage decodes each word into a four-entry queue; the back end executes
// one queued word at a time. A rule's characters are read through the
// single read port of the rule text memory; a zero-length rule emits no
// word. Output words leave after a read stage and an output register. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lsystem_symbol_rewriter_core import lsr_pkg::*; #(
  parameter int unsigned MAX_RULE_LEN = 64,
  parameter int unsigned NUM_LETTERS  = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] symbol_i,
  input  logic [5:0] position_i,
  input  logic [7:0] rule_char_i,
  input  logic [6:0] rule_length_i,
  input  logic       registered_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       last_o
);

  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_wdata, q_rdata;

  lsr_front #(
    .MAX_RULE_LEN(MAX_RULE_LEN),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .symbol_i     (symbol_i),
    .position_i   (position_i),
    .rule_char_i  (rule_char_i),
    .rule_length_i(rule_length_i),
    .registered_i (registered_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  lsr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  lsr_back #(
    .MAX_RULE_LEN(MAX_RULE_LEN),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_symbol_o(out_symbol_o),
    .last_o      (last_o)
  );

endmodule
